FILE: hw/rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants for the stencil edge threshold block.
// ----------------------------------------------------------------------------
package ste_pkg;

   localparam int PIXEL_W   = 8;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 10;
   localparam int FW_W      = 8;
   localparam int FH_W      = 11;
   localparam int CSR_W     = 32;
   localparam int CSR_AW    = 3;

   localparam logic [FW_W-1:0] FW_RESET = 8'd100;
   localparam logic [FH_W-1:0] FH_RESET = 11'd72;

   localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

   // one accepted pixel, as handed to the result stage
   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row_prev;
      logic [OUT_ROW_W-1:0] row_cur;
      logic [PIXEL_W-1:0]   pixel;
      logic                 has_a;     // result for the row above
      logic                 has_b;     // border zero of the last row
      logic                 interior;
      logic                 last_col;
   } ste_item_type;

   // line buffer read data for one item
   typedef struct packed {
      logic [PIXEL_W-1:0] centre;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] above;
   } ste_taps_type;

endpackage

FILE: hw/rtl/stencil_edge_threshold.sv
// ----------------------------------------------------------------------------
// stencil_edge_threshold
// Streaming 5-point edge detector with threshold over a raster of grey pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the req_ channel in raster order, one item per pixel.
//   When pixel (x,y) is taken, the result for (x,y-1) is produced; in the
//   last row the border zero for (x,y) follows it. Results leave on the rsp_
//   channel with their column and row; frame_done marks the last of a frame.
//   An accepted pixel passes the result stage, then the output register,
//   before rsp_valid. One pixel per cycle is taken while the output drains,
//   except in the last row, where two results per pixel share the single
//   output port. After reset the line memories are zeroed, one entry a cycle,
//   over all MAX_WIDTH entries; req_ready stays low meanwhile (CSR writes still work).
//   frame_width and frame_height sit at byte addresses 0 and 4; values
//   outside 3..MAX_WIDTH and 3..MAX_HEIGHT are saturated on use.
//   When rsp_ready is low, the output register holds its item and one pixel
//   more is held in the result stage; req_ready then drops.
// ----------------------------------------------------------------------------
module stencil_edge_threshold #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ste_pkg::PIXEL_W-1:0]        req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ste_pkg::OUT_COL_W-1:0]      rsp_out_col,
   output logic [ste_pkg::OUT_ROW_W-1:0]      rsp_out_row,
   output logic [ste_pkg::PIXEL_W-1:0]        rsp_edge_value,
   output logic                               rsp_frame_done,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ste_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [ste_pkg::CSR_W-1:0]          csr_pwdata,
   output logic [ste_pkg::CSR_W-1:0]          csr_prdata,
   output logic                               csr_pready
);
   import ste_pkg::*;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W  = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
   localparam int HEIGHT_W = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;

   logic [FW_W-1:0]  frame_width_ff;
   logic [FH_W-1:0]  frame_height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WIDTH_W-1:0]  fw_ext, w_use, x_ext;
   logic [HEIGHT_W-1:0] fh_ext, h_use, y_ext;
   logic                last_col, last_row, accept, csr_wr;
   logic                res_take_ok, clearing;
   logic [COL_W-1:0]    right_addr;
   ste_item_type        item;
   ste_taps_type        taps;

   // ---- configuration registers ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---- position of the arriving pixel ----
   always_comb begin
      fw_ext = WIDTH_W'(frame_width_ff);
      if (fw_ext < WIDTH_W'(3)) begin
         w_use = WIDTH_W'(3);
      end else if (fw_ext > WIDTH_W'(MAX_WIDTH)) begin
         w_use = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_use = fw_ext;
      end

      fh_ext = HEIGHT_W'(frame_height_ff);
      if (fh_ext < HEIGHT_W'(3)) begin
         h_use = HEIGHT_W'(3);
      end else if (fh_ext > HEIGHT_W'(MAX_HEIGHT)) begin
         h_use = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_use = fh_ext;
      end

      x_ext    = WIDTH_W'(col_ff);
      y_ext    = HEIGHT_W'(row_ff);
      last_col = (x_ext + WIDTH_W'(1)) >= w_use;
      last_row = (y_ext + HEIGHT_W'(1)) >= h_use;

      // right neighbour is not used on the last column
      right_addr = last_col ? '0 : col_ff + COL_W'(1);

      item.col      = OUT_COL_W'(col_ff);
      item.row_prev = OUT_ROW_W'(row_ff - ROW_W'(1));
      item.row_cur  = OUT_ROW_W'(row_ff);
      item.pixel    = req_pixel_in;
      item.has_a    = (row_ff != '0);
      item.has_b    = last_row;
      item.interior = (row_ff != ROW_W'(1)) && (y_ext < h_use)
                    && (col_ff != '0) && !last_col;
      item.last_col = last_col;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign req_ready = res_take_ok && !clearing;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   ste_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .col        (col_ff),
      .right_addr (right_addr),
      .pixel      (req_pixel_in),
      .taps       (taps),
      .clearing   (clearing)
   );

   ste_result u_result (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .item           (item),
      .taps           (taps),
      .take_ok        (res_take_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

FILE: hw/rtl/ste_line_buf.sv
// ----------------------------------------------------------------------------
// ste_line_buf
// Two line memories (rows y-1 and y-2) with registered reads,
// read-modify-write of the older row and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ste_line_buf #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [$clog2(MAX_WIDTH)-1:0]       col,
   input  logic [$clog2(MAX_WIDTH)-1:0]       right_addr,
   input  logic [ste_pkg::PIXEL_W-1:0]        pixel,
   output ste_pkg::ste_taps_type              taps,
   output logic                               clearing
);
   import ste_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam logic [COL_W-1:0] LAST_ADDR = COL_W'(MAX_WIDTH - 1);

   logic [PIXEL_W-1:0] line_prev_ff  [MAX_WIDTH];
   logic [PIXEL_W-1:0] line_prev2_ff [MAX_WIDTH];

   logic [PIXEL_W-1:0] centre_ff, right_ff, above_ff;
   logic [COL_W-1:0]   col_q_ff;
   logic               wr2_ff, wr2_in;
   logic               clr_busy_ff, clr_busy_in;
   logic [COL_W-1:0]   clr_addr_ff, clr_addr_in;

   always_comb begin
      wr2_in      = accept;
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr2_ff      <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         wr2_ff      <= wr2_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // row y-1: read centre and right, overwrite centre with the new pixel; above is read from row y-2
   always_ff @(posedge clock) begin
      if (accept) begin
         centre_ff <= line_prev_ff[col];
         right_ff  <= line_prev_ff[right_addr];
         above_ff  <= line_prev2_ff[col];
         col_q_ff  <= col;
      end
      if (clr_busy_ff) begin
         line_prev_ff[clr_addr_ff] <= '0;
      end else if (accept) begin
         line_prev_ff[col] <= pixel;
      end
   end

   // row y-2: the old centre moves down in the cycle after the read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         line_prev2_ff[clr_addr_ff] <= '0;
      end else if (wr2_ff) begin
         line_prev2_ff[col_q_ff] <= centre_ff;
      end
   end

   assign taps.centre = centre_ff;
   assign taps.right  = right_ff;
   assign taps.above  = above_ff;
   assign clearing    = clr_busy_ff;

endmodule

FILE: hw/rtl/ste_result.sv
// ----------------------------------------------------------------------------
// ste_result
// Stencil sum and threshold, up to two results per item, output register.
// ----------------------------------------------------------------------------
module ste_result (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  ste_pkg::ste_item_type               item,
   input  ste_pkg::ste_taps_type               taps,
   output logic                                take_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ste_pkg::OUT_COL_W-1:0]       rsp_out_col,
   output logic [ste_pkg::OUT_ROW_W-1:0]       rsp_out_row,
   output logic [ste_pkg::PIXEL_W-1:0]         rsp_edge_value,
   output logic                                rsp_frame_done
);
   import ste_pkg::*;

   localparam int SUM_W = PIXEL_W + 4;

   ste_item_type         item_ff;
   logic                 s1_v_ff, s1_v_in;
   logic                 need_a_ff, need_a_in;
   logic                 need_b_ff, need_b_in;
   logic [PIXEL_W-1:0]   left_ff;
   logic                 out_v_ff, out_v_in;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;
   logic [PIXEL_W-1:0]   out_edge_ff;
   logic                 out_done_ff;

   logic               out_free, any_need, both_need, emit, s1_leave, is_edge;
   logic [SUM_W-1:0]   lhs, rhs;

   always_comb begin
      out_free  = !out_v_ff || rsp_ready;
      any_need  = need_a_ff || need_b_ff;
      both_need = need_a_ff && need_b_ff;
      emit      = s1_v_ff && any_need && out_free;
      s1_leave  = s1_v_ff && (!any_need || (out_free && !both_need));
      take_ok   = !s1_v_ff || s1_leave;

      // 4*centre > 4*below + left + right + 4*above
      lhs = {2'b00, taps.centre, 2'b00};
      rhs = {2'b00, item_ff.pixel, 2'b00} + {4'b0000, left_ff}
          + {4'b0000, taps.right} + {2'b00, taps.above, 2'b00};
      is_edge = item_ff.interior && (lhs > rhs);

      s1_v_in   = s1_v_ff;
      need_a_in = need_a_ff;
      need_b_in = need_b_ff;
      if (emit) begin
         if (need_a_ff) begin
            need_a_in = 1'b0;
         end else begin
            need_b_in = 1'b0;
         end
      end
      if (s1_leave) begin
         s1_v_in = 1'b0;
      end
      if (load) begin
         s1_v_in   = 1'b1;
         need_a_in = item.has_a;
         need_b_in = item.has_b;
      end

      out_v_in = out_v_ff;
      if (emit) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         need_a_ff <= 1'b0;
         need_b_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         s1_v_ff   <= s1_v_in;
         need_a_ff <= need_a_in;
         need_b_ff <= need_b_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
      // left neighbour of the next item is this item's centre
      if (s1_leave) begin
         left_ff <= taps.centre;
      end
      if (emit) begin
         out_col_ff <= item_ff.col;
         if (need_a_ff) begin
            out_row_ff  <= item_ff.row_prev;
            out_edge_ff <= is_edge ? EDGE_ON : EDGE_OFF;
            out_done_ff <= 1'b0;
         end else begin
            out_row_ff  <= item_ff.row_cur;
            out_edge_ff <= EDGE_OFF;
            out_done_ff <= item_ff.last_col;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_edge_value = out_edge_ff;
   assign rsp_frame_done = out_done_ff;

endmodule

FILE: tb/sv/ste_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ste_result_checker
// Watches the pixel, result and register ports of the edge threshold block.
// Keeps its own line buffers, counters and register copies, works out the
// results due for every accepted pixel and compares each result, field by
// field, with the oldest one due.
// ----------------------------------------------------------------------------
module ste_result_checker
   import ste_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [PIXEL_W-1:0]   req_pixel_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [OUT_COL_W-1:0] rsp_out_col,
   input  logic [OUT_ROW_W-1:0] rsp_out_row,
   input  logic [PIXEL_W-1:0]   rsp_edge_value,
   input  logic                 rsp_frame_done,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_W-1:0]     csr_pwdata,
   input  logic                 csr_pready,
   output int                   fail_count,
   output int                   results_due,
   output int                   results_seen,
   output int                   edge_hits,
   output int                   frame_ends
);

   localparam int MAX_W = 128;
   localparam int MAX_H = 1024;

   typedef struct {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic [PIXEL_W-1:0]   level;
      logic                 done;
   } edge_result_type;

   logic [PIXEL_W-1:0]   row_above  [MAX_W];
   logic [PIXEL_W-1:0]   row_above2 [MAX_W];
   logic [OUT_COL_W-1:0] col_pos;
   logic [OUT_ROW_W-1:0] row_pos;
   logic [FW_W-1:0]      width_reg;
   logic [FH_W-1:0]      height_reg;
   edge_result_type      edges_due [$];
   int                   mismatches;
   int                   seen_count;
   int                   hit_count;
   int                   end_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t  ERROR %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // results caused by one pixel: the row above at this column, then in the
   // last row the border zero of the pixel itself
   task automatic predict_edge_results(input logic [PIXEL_W-1:0] px);
      int unsigned  w;
      int unsigned  h;
      int unsigned  x;
      int unsigned  y;
      int           sum;
      logic         at_last_col;
      logic         at_last_row;
      logic [PIXEL_W-1:0] centre;
      logic [PIXEL_W-1:0] above;
      edge_result_type r;
      w = width_reg;
      h = height_reg;
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      if (h < 3) h = 3;
      if (h > MAX_H) h = MAX_H;
      x = col_pos;
      y = row_pos;
      at_last_col = (x + 1 >= w);
      at_last_row = (y + 1 >= h);
      centre = row_above[x];
      above  = row_above2[x];
      row_above2[x] = centre;
      row_above[x]  = px;
      if (y >= 1) begin
         r.col   = OUT_COL_W'(x);
         r.row   = OUT_ROW_W'(y - 1);
         r.level = EDGE_OFF;
         r.done  = 1'b0;
         if (y - 1 != 0 && y < h && x != 0 && !at_last_col) begin
            sum = 4 * int'(centre) - 4 * int'(px) - int'(row_above2[x-1])
                  - int'(row_above[x+1]) - 4 * int'(above);
            if (sum > 0) r.level = EDGE_ON;
         end
         edges_due.push_back(r);
      end
      if (at_last_row) begin
         r.col   = OUT_COL_W'(x);
         r.row   = OUT_ROW_W'(y);
         r.level = EDGE_OFF;
         r.done  = at_last_col;
         edges_due.push_back(r);
      end
      if (at_last_col) begin
         col_pos = '0;
         row_pos = at_last_row ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_W; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
         end
         col_pos    = '0;
         row_pos    = '0;
         width_reg  = FW_RESET;
         height_reg = FH_RESET;
         edges_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_FRAME_WIDTH) width_reg = csr_pwdata[FW_W-1:0];
            else height_reg = csr_pwdata[FH_W-1:0];
         end
         if (req_valid && req_ready) predict_edge_results(req_pixel_in);
         if (rsp_valid && rsp_ready) begin
            seen_count++;
            if (rsp_edge_value == EDGE_ON) hit_count++;
            if (rsp_frame_done) end_count++;
            if (edges_due.size() == 0) begin
               report_mismatch("result with nothing due, col", rsp_out_col, -1);
            end else begin
               want = edges_due.pop_front();
               if (rsp_out_col != want.col)
                  report_mismatch("out_col", rsp_out_col, want.col);
               if (rsp_out_row != want.row)
                  report_mismatch("out_row", rsp_out_row, want.row);
               if (rsp_edge_value != want.level)
                  report_mismatch($sformatf("edge_value at (%0d,%0d)", want.col, want.row),
                                  rsp_edge_value, want.level);
               if (rsp_frame_done != want.done)
                  report_mismatch($sformatf("frame_done at (%0d,%0d)", want.col, want.row),
                                  rsp_frame_done, want.done);
            end
         end
      end
      fail_count   <= mismatches;
      results_due  <= edges_due.size();
      results_seen <= seen_count;
      edge_hits    <= hit_count;
      frame_ends   <= end_count;
   end

endmodule

FILE: tb/sv/tb_stencil_edge_threshold.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stencil_edge_threshold
// Streams pixel frames into the edge threshold block under changing frame
// sizes, idles both channels at random and holds the result side off for a
// long stretch; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_stencil_edge_threshold;
   import ste_pkg::*;

   localparam int RANDOM_PIXELS  = 850;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_HOLD      = 400;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic [PIXEL_W-1:0]   req_pixel_in = '0;
   logic                 rsp_ready    = 1'b0;
   logic                 csr_psel     = 1'b0;
   logic                 csr_penable  = 1'b0;
   logic                 csr_pwrite   = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr    = '0;
   logic [CSR_W-1:0]     csr_pwdata   = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [OUT_COL_W-1:0] rsp_out_col;
   logic [OUT_ROW_W-1:0] rsp_out_row;
   logic [PIXEL_W-1:0]   rsp_edge_value;
   logic                 rsp_frame_done;
   logic [CSR_W-1:0]     csr_prdata;
   logic                 csr_pready;

   int fail_count;
   int results_due;
   int results_seen;
   int edge_hits;
   int frame_ends;

   int pixels_sent   = 0;
   int settings_used = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   stencil_edge_threshold u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_done (rsp_frame_done),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   ste_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_done (rsp_frame_done),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .results_due    (results_due),
      .results_seen   (results_seen),
      .edge_hits      (edge_hits),
      .frame_ends     (frame_ends)
   );

   always #5 clock = ~clock;

   // result side: random stalls, or a counted hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic set_idle_mix();
      if (pixels_sent < RANDOM_PIXELS / 3) begin
         send_idle_pct = 30;
         recv_idle_pct = 88;
      end else if (pixels_sent < 2 * RANDOM_PIXELS / 3) begin
         send_idle_pct = 88;
         recv_idle_pct = 30;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   task automatic push_pixel(input logic [PIXEL_W-1:0] px);
      set_idle_mix();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   // stop offering and wait until every result due has come out
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [CSR_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel(input int style);
      case (style)
         0: return PIXEL_W'($urandom_range(255));
         1: return $urandom_range(1) ? EDGE_ON : EDGE_OFF;
         // flat background with the odd bright spike
         default: return ($urandom_range(7) == 0) ? EDGE_ON
                                                  : PIXEL_W'($urandom_range(30, 60));
      endcase
   endfunction

   // frame size and pixel count for one block of stimulus; the first few
   // blocks pin the register extremes, out-of-range values included
   task automatic pick_frame(input int blk, output logic [CSR_W-1:0] fw,
                             output logic [CSR_W-1:0] fh, output int count);
      int w_eff;
      int h_eff;
      int pick;
      case (blk)
         0: begin fw = 128;  fh = 3;    count = 260; end
         1: begin fw = 255;  fh = 2047; count = 40;  end
         2: begin fw = 0;    fh = 0;    count = 27;  end
         3: begin fw = 1;    fh = 1024; count = 30;  end
         4: begin fw = 2;    fh = 1;    count = 20;  end
         5: begin fw = 20;   fh = 6;    count = 60;  end
         default: begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               fw = $urandom_range(255);
               fh = $urandom_range(3, 6);
            end else if (pick == 1) begin
               fw = $urandom_range(3, 8);
               fh = $urandom_range(2047);
            end else begin
               fw = $urandom_range(3, 12);
               fh = $urandom_range(3, 8);
            end
            w_eff = (fw < 3) ? 3 : (fw > 128) ? 128 : fw;
            h_eff = (fh < 3) ? 3 : (fh > 1024) ? 1024 : fh;
            if (w_eff * h_eff <= 96) begin
               count = w_eff * h_eff * $urandom_range(1, 2);
               // now and then stop part way through a frame
               if ($urandom_range(3) == 0) count += $urandom_range(1, w_eff + 2);
            end else begin
               count = $urandom_range(20, 80);
            end
         end
      endcase
   endtask

   initial begin
      logic [CSR_W-1:0] fw;
      logic [CSR_W-1:0] fh;
      int               count;
      int               style;
      int               blk;
      int               random_sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bright centre on dark, dark centre on bright, then row 0
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 3);
      settings_used++;
      for (int i = 0; i < 9; i++) push_pixel((i == 4) ? EDGE_ON : EDGE_OFF);
      for (int i = 0; i < 9; i++) push_pixel((i == 4) ? EDGE_OFF : EDGE_ON);
      repeat (3) push_pixel(EDGE_ON);
      settle();

      blk         = 0;
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         pick_frame(blk, fw, fh, count);
         csr_write(REG_FRAME_WIDTH, fw);
         csr_write(REG_FRAME_HEIGHT, fh);
         settings_used++;
         style = $urandom_range(2);
         // long stall on the result side while pixels keep coming
         if (blk == 5) hold_request = LONG_HOLD;
         repeat (count) push_pixel(pick_pixel(style));
         random_sent += count;
         settle();
         blk++;
      end

      $display("Streamed %0d pixels through %0d frame size settings, extremes included.",
               pixels_sent, settings_used);
      $display("Checked %0d results: %0d edge hits, %0d frame ends, %0d mismatches.",
               results_seen, edge_hits, frame_ends, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
